// ===== sv/edfb_pkg.sv =====
// edfb_pkg: shared types and constants for the echo delay FIR feedback core.
// Register map, reset values, configuration struct, sequencer states.
// No dependencies.
package edfb_pkg;

	localparam int SAMPLE_W = 16;
	localparam int ADDR_W   = 6;
	localparam int DATA_W   = 64;
	localparam int TAP_N    = 8;
	localparam int COEF_W   = 8;

	typedef enum logic [2:0] {
		REG_TARGET_LENGTH = 3'd0,
		REG_DELAY_OFFSET  = 3'd1,
		REG_FEEDBACK_GAIN = 3'd2,
		REG_FILTER_MIX    = 3'd3,
		REG_FREEZE        = 3'd4,
		REG_FILTER_GAIN   = 3'd5,
		REG_COEFFICIENTS  = 3'd6
	} reg_idx_t;

	localparam logic [13:0] RST_TARGET_LENGTH = 14'd4096;
	localparam logic [13:0] RST_DELAY_OFFSET  = 14'd0;
	localparam logic [7:0]  RST_FEEDBACK_GAIN = 8'd0;
	localparam logic [8:0]  RST_FILTER_MIX    = 9'd256;
	localparam logic        RST_FREEZE        = 1'b0;
	localparam logic [3:0]  RST_FILTER_GAIN   = 4'd1;
	localparam logic [63:0] RST_COEFFICIENTS  = 64'd127;

	localparam logic [8:0]  MIX_FULL = 9'd256;

	typedef struct packed {
		logic [13:0] target_length;
		logic [13:0] delay_offset;
		logic [7:0]  feedback_gain;
		logic [8:0]  filter_mix;
		logic        freeze;
		logic [3:0]  filter_gain;
		logic [63:0] coefficients;
	} cfg_t;

	typedef struct packed {
		logic load;
		logic sum;
		logic mix;
		logic blend;
		logic feed;
	} filt_ctl_t;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_INDEX,
		ST_DIV,
		ST_TAPS,
		ST_SUM,
		ST_MIX,
		ST_BLEND,
		ST_FEED,
		ST_WB
	} state_t;

endpackage

// ===== sv/edfb_in_if.sv =====
// edfb_in_if: input item channel, valid/ready with sample and head reset flag.
// Depends on edfb_pkg.
interface edfb_in_if;
	import edfb_pkg::*;
	logic                       valid;
	logic                       ready;
	logic signed [SAMPLE_W-1:0] sample;
	logic                       reset_head;
	modport source (output valid, sample, reset_head, input ready);
	modport sink (input valid, sample, reset_head, output ready);
endinterface

// ===== sv/edfb_out_if.sv =====
// edfb_out_if: result item channel, valid/ready with the echo sample.
// Depends on edfb_pkg.
interface edfb_out_if;
	import edfb_pkg::*;
	logic                       valid;
	logic                       ready;
	logic signed [SAMPLE_W-1:0] echo_sample;
	modport source (output valid, echo_sample, input ready);
	modport sink (input valid, echo_sample, output ready);
endinterface

// ===== sv/edfb_regs.sv =====
// edfb_regs: APB-style configuration registers with read-back.
// Depends on edfb_pkg.
module edfb_regs (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [edfb_pkg::ADDR_W-1:0] paddr,
	input  logic [edfb_pkg::DATA_W-1:0] pwdata,
	output logic [edfb_pkg::DATA_W-1:0] prdata,
	output edfb_pkg::cfg_t              cfg
);
	import edfb_pkg::*;

	cfg_t     cfg_q;
	reg_idx_t idx;
	logic     wr;

	assign idx = reg_idx_t'(paddr[ADDR_W-1:3]);
	assign wr  = psel && penable && pwrite;
	assign cfg = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.target_length <= RST_TARGET_LENGTH;
			cfg_q.delay_offset  <= RST_DELAY_OFFSET;
			cfg_q.feedback_gain <= RST_FEEDBACK_GAIN;
			cfg_q.filter_mix    <= RST_FILTER_MIX;
			cfg_q.freeze        <= RST_FREEZE;
			cfg_q.filter_gain   <= RST_FILTER_GAIN;
			cfg_q.coefficients  <= RST_COEFFICIENTS;
		end else if (wr) begin
			case (idx)
				REG_TARGET_LENGTH: cfg_q.target_length <= pwdata[13:0];
				REG_DELAY_OFFSET:  cfg_q.delay_offset  <= pwdata[13:0];
				REG_FEEDBACK_GAIN: cfg_q.feedback_gain <= pwdata[7:0];
				REG_FILTER_MIX:    cfg_q.filter_mix    <= pwdata[8:0];
				REG_FREEZE:        cfg_q.freeze        <= pwdata[0];
				REG_FILTER_GAIN:   cfg_q.filter_gain   <= pwdata[3:0];
				REG_COEFFICIENTS:  cfg_q.coefficients  <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_TARGET_LENGTH: prdata = DATA_W'(cfg_q.target_length);
			REG_DELAY_OFFSET:  prdata = DATA_W'(cfg_q.delay_offset);
			REG_FEEDBACK_GAIN: prdata = DATA_W'(cfg_q.feedback_gain);
			REG_FILTER_MIX:    prdata = DATA_W'(cfg_q.filter_mix);
			REG_FREEZE:        prdata = DATA_W'(cfg_q.freeze);
			REG_FILTER_GAIN:   prdata = DATA_W'(cfg_q.filter_gain);
			REG_COEFFICIENTS:  prdata = cfg_q.coefficients;
			default:           prdata = '0;
		endcase
	end

endmodule

// ===== sv/edfb_ram.sv =====
// edfb_ram: echo store, one write port and one registered read port.
// No dependencies.
module edfb_ram #(
	parameter int DEPTH = 8192,
	parameter int AW    = 13
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [15:0]   wdata,
	input  logic [AW-1:0] raddr,
	output logic [15:0]   rdata
);
	logic [15:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== sv/edfb_mod.sv =====
// edfb_mod: bit-serial remainder unit, one dividend bit per cycle.
// No dependencies.
module edfb_mod #(
	parameter int NW = 14,
	parameter int LW = 14
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [NW-1:0] dividend,
	input  logic [LW-1:0] divisor,
	output logic          done,
	output logic [LW-1:0] rem
);
	localparam int CW = $clog2(NW + 1);

	logic [CW-1:0] cnt_q;
	logic          done_q;
	logic [NW-1:0] dvd_q;
	logic [LW-1:0] dvs_q;
	logic [LW-1:0] rem_q;
	logic [LW:0]   sh;
	logic [LW-1:0] rem_nx;

	assign sh     = {rem_q, dvd_q[NW-1]};
	assign rem_nx = (sh >= {1'b0, dvs_q}) ? LW'(sh - {1'b0, dvs_q}) : sh[LW-1:0];
	assign done   = done_q;
	assign rem    = rem_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= (cnt_q == CW'(1));
			if (start) begin
				cnt_q <= CW'(NW);
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			dvs_q <= divisor;
			rem_q <= '0;
		end else if (cnt_q != '0) begin
			dvd_q <= dvd_q << 1;
			rem_q <= rem_nx;
		end
	end

endmodule

// ===== sv/edfb_filt.sv =====
// edfb_filt: 8-tap FIR history, tap products, gain, blend and feedback datapath.
// Stepped by the sequencer in the top level. Depends on edfb_pkg.
module edfb_filt (
	input  logic                          clk,
	input  logic                          arst_n,
	input  edfb_pkg::filt_ctl_t           ctl,
	input  edfb_pkg::cfg_t                cfg,
	input  logic [15:0]                   rdata,
	input  logic signed [edfb_pkg::SAMPLE_W-1:0] sample,
	output logic signed [edfb_pkg::SAMPLE_W-1:0] echo,
	output logic [15:0]                   wb
);
	import edfb_pkg::*;

	logic signed [15:0]       hist_q  [TAP_N];
	logic signed [15:0]       hist_in [TAP_N];
	logic signed [COEF_W-1:0] coef    [TAP_N];
	logic signed [23:0]       prod    [TAP_N];
	logic [15:0]              term_s1 [TAP_N];
	logic signed [15:0]       d;
	logic signed [15:0]       d_q;
	logic [15:0]              sum;
	logic [19:0]              fprod;
	logic signed [15:0]       f_q;
	logic [8:0]               mix;
	logic signed [16:0]       diff;
	logic signed [26:0]       pmix;
	logic signed [26:0]       pmix_q;
	logic signed [27:0]       acc;
	logic signed [27:0]       accr;
	logic signed [15:0]       m_q;
	logic signed [23:0]       q;
	logic signed [23:0]       q_q;
	logic signed [23:0]       qr;
	logic signed [16:0]       t;
	logic signed [17:0]       tot;

	assign d = {rdata[14:0], 1'b0};

	always_comb begin
		hist_in[TAP_N-1] = d;
		for (int k = 0; k < TAP_N - 1; k++) begin
			hist_in[k] = hist_q[k+1];
		end
		for (int k = 0; k < TAP_N; k++) begin
			coef[k] = cfg.coefficients[COEF_W*k +: COEF_W];
			prod[k] = coef[k] * hist_in[k];
		end
	end

	always_comb begin
		sum = '0;
		for (int k = 0; k < TAP_N; k++) begin
			sum = sum + term_s1[k];
		end
		fprod = 20'(sum) * 20'(cfg.filter_gain);
	end

	assign mix  = (cfg.filter_mix > MIX_FULL) ? MIX_FULL : cfg.filter_mix;
	assign diff = {f_q[15], f_q} - {d_q[15], d_q};
	assign pmix = diff * $signed({1'b0, mix});
	assign acc  = $signed({{4{d_q[15]}}, d_q, 8'd0}) + {pmix_q[26], pmix_q};
	assign accr = acc + (acc[27] ? 28'sd255 : 28'sd0);
	assign q    = m_q * $signed(cfg.feedback_gain);
	assign qr   = q_q + (q_q[23] ? 24'sd127 : 24'sd0);
	assign t    = qr[23:7];
	assign tot  = {{2{sample[15]}}, sample} + {t[16], t};
	assign wb   = tot[16:1];
	assign echo = m_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < TAP_N; k++) begin
				hist_q[k] <= '0;
			end
		end else if (ctl.load) begin
			for (int k = 0; k < TAP_N; k++) begin
				hist_q[k] <= hist_in[k];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			d_q <= d;
			for (int k = 0; k < TAP_N; k++) begin
				term_s1[k] <= prod[k][22:7];
			end
		end
		if (ctl.sum) begin
			f_q <= fprod[15:0];
		end
		if (ctl.mix) begin
			pmix_q <= pmix;
		end
		if (ctl.blend) begin
			m_q <= accr[23:8];
		end
		if (ctl.feed) begin
			q_q <= q;
		end
	end

endmodule

// ===== sv/echo_delay_fir_feedback_core.sv =====
// echo_delay_fir_feedback_core: top level, sequencer, write head and read index.
// Depends on edfb_pkg, edfb_in_if, edfb_out_if, edfb_regs, edfb_ram, edfb_mod,
// edfb_filt.
//
// Feedback echo over a circular store of up to ECHO_DEPTH 16-bit entries. Each
// input item advances the write head, reads the store at head plus delay_offset
// (true modulo of the current length), doubles it, runs it through an 8-tap
// Q1.7 FIR and filter_gain, blends raw and filtered by filter_mix, returns the
// blend as one result item and, unless freeze is set, writes back
// (sample + blend*feedback_gain/128)/2 at the head. While head plus offset lies
// between minus one length and two lengths the read position is found directly;
// otherwise the bit-serial remainder unit divides the head-plus-offset magnitude,
// NW bits wide, by the length. The taps, sum, mix, blend, feed and write-back
// states follow in that order, and write-back waits for a free output register.
// The single store port pair and the shared filter datapath carry
// one item at a time; a finished result waits in an output register while the
// next item is taken. After reset a clearing pass writes zeros to all
// ECHO_DEPTH entries, one per cycle, and no item is accepted until it ends;
// configuration writes are taken at any time.
module echo_delay_fir_feedback_core #(
	parameter int ECHO_DEPTH = 8192
) (
	input  logic                        clk,
	input  logic                        arst_n,
	edfb_in_if.sink                     din,
	edfb_out_if.source                  dout,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [edfb_pkg::ADDR_W-1:0] paddr,
	input  logic [edfb_pkg::DATA_W-1:0] pwdata,
	output logic [edfb_pkg::DATA_W-1:0] prdata,
	output logic                        pready
);
	import edfb_pkg::*;

	localparam int AW = $clog2(ECHO_DEPTH);
	localparam int LW = $clog2(ECHO_DEPTH + 1);
	localparam int CW = (LW > 14) ? LW : 14;
	localparam int XW = ((AW > 13) ? AW : 13) + 2;
	localparam int NW = XW - 1;
	localparam logic [AW-1:0] LAST_ADDR = AW'(ECHO_DEPTH - 1);

	cfg_t                 cfg;
	filt_ctl_t            ctl;
	state_t               state_q, state_nx;
	logic [AW-1:0]        clr_cnt_q;
	logic [AW-1:0]        wi_q;
	logic [LW-1:0]        len_q;
	logic                 neg_q;
	logic signed [15:0]   sample_q;
	logic                 out_valid_q;
	logic signed [15:0]   out_data_q;

	logic                 accept;
	logic [AW-1:0]        base_wi;
	logic [LW-1:0]        base_len;
	logic [LW-1:0]        wi_inc;
	logic [AW-1:0]        wi_nx;
	logic [CW-1:0]        tgt_c;
	logic [LW-1:0]        clamp_len;

	logic signed [XW-1:0] x;
	logic signed [XW-1:0] lenx;
	logic signed [XW-1:0] xp;
	logic signed [XW-1:0] xm;
	logic signed [XW-1:0] xabs;
	logic                 fast;
	logic [AW-1:0]        fast_pos;
	logic [LW-1:0]        rem;
	logic [LW-1:0]        rpos;
	logic                 mod_start;
	logic                 mod_done;

	logic [AW-1:0]        rd_addr;
	logic [15:0]          rd_data;
	logic                 mem_we;
	logic [AW-1:0]        wr_addr;
	logic [15:0]          wr_data;
	logic [15:0]          wb;
	logic signed [15:0]   echo;
	logic                 out_load;

	assign pready = 1'b1;

	edfb_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.cfg     (cfg)
	);

	edfb_ram #(
		.DEPTH (ECHO_DEPTH),
		.AW    (AW)
	) u_ram (
		.clk   (clk),
		.we    (mem_we),
		.waddr (wr_addr),
		.wdata (wr_data),
		.raddr (rd_addr),
		.rdata (rd_data)
	);

	edfb_mod #(
		.NW (NW),
		.LW (LW)
	) u_mod (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (mod_start),
		.dividend (xabs[NW-1:0]),
		.divisor  (len_q),
		.done     (mod_done),
		.rem      (rem)
	);

	edfb_filt u_filt (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl),
		.cfg    (cfg),
		.rdata  (rd_data),
		.sample (sample_q),
		.echo   (echo),
		.wb     (wb)
	);

	// head advance at acceptance
	assign accept    = din.valid && din.ready;
	assign base_wi   = din.reset_head ? '0 : wi_q;
	assign base_len  = din.reset_head ? '0 : len_q;
	assign wi_inc    = LW'(base_wi) + LW'(1);
	assign wi_nx     = ((base_len == '0) || (wi_inc == base_len)) ? '0 : wi_inc[AW-1:0];
	assign tgt_c     = CW'(cfg.target_length);

	always_comb begin
		if (tgt_c == '0) begin
			clamp_len = LW'(1);
		end else if (tgt_c > CW'(ECHO_DEPTH)) begin
			clamp_len = LW'(ECHO_DEPTH);
		end else begin
			clamp_len = LW'(tgt_c);
		end
	end

	// read position
	assign x    = $signed(XW'(wi_q)) + XW'($signed(cfg.delay_offset));
	assign lenx = $signed(XW'(len_q));
	assign xp   = x + lenx;
	assign xm   = x - lenx;
	assign xabs = x[XW-1] ? -x : x;

	always_comb begin
		fast     = 1'b0;
		fast_pos = x[AW-1:0];
		if (x[XW-1]) begin
			fast     = !xp[XW-1];
			fast_pos = xp[AW-1:0];
		end else if (x < lenx) begin
			fast     = 1'b1;
			fast_pos = x[AW-1:0];
		end else if (xm < lenx) begin
			fast     = 1'b1;
			fast_pos = xm[AW-1:0];
		end
	end

	assign rpos    = (neg_q && (rem != '0)) ? len_q - rem : rem;
	assign rd_addr = (state_q == ST_DIV) ? rpos[AW-1:0] : fast_pos;

	assign out_load = (state_q == ST_WB) && (!out_valid_q || dout.ready);
	assign dout.valid       = out_valid_q;
	assign dout.echo_sample = out_data_q;

	always_comb begin
		state_nx  = state_q;
		din.ready = 1'b0;
		mod_start = 1'b0;
		mem_we    = 1'b0;
		wr_addr   = wi_q;
		wr_data   = wb;
		ctl       = '0;
		case (state_q)
			ST_CLEAR: begin
				mem_we  = 1'b1;
				wr_addr = clr_cnt_q;
				wr_data = '0;
				if (clr_cnt_q == LAST_ADDR) begin
					state_nx = ST_IDLE;
				end
			end
			ST_IDLE: begin
				din.ready = 1'b1;
				if (din.valid) begin
					state_nx = ST_INDEX;
				end
			end
			ST_INDEX: begin
				if (fast) begin
					state_nx = ST_TAPS;
				end else begin
					mod_start = 1'b1;
					state_nx  = ST_DIV;
				end
			end
			ST_DIV: begin
				if (mod_done) begin
					state_nx = ST_TAPS;
				end
			end
			ST_TAPS: begin
				ctl.load = 1'b1;
				state_nx = ST_SUM;
			end
			ST_SUM: begin
				ctl.sum  = 1'b1;
				state_nx = ST_MIX;
			end
			ST_MIX: begin
				ctl.mix  = 1'b1;
				state_nx = ST_BLEND;
			end
			ST_BLEND: begin
				ctl.blend = 1'b1;
				state_nx  = ST_FEED;
			end
			ST_FEED: begin
				ctl.feed = 1'b1;
				state_nx = ST_WB;
			end
			ST_WB: begin
				if (out_load) begin
					mem_we   = !cfg.freeze;
					state_nx = ST_IDLE;
				end
			end
			default: state_nx = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_cnt_q   <= '0;
			wi_q        <= '0;
			len_q       <= '0;
			neg_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (state_q == ST_CLEAR) begin
				clr_cnt_q <= clr_cnt_q + AW'(1);
			end
			if (accept) begin
				wi_q  <= wi_nx;
				len_q <= (wi_nx == '0) ? clamp_len : base_len;
			end
			if (mod_start) begin
				neg_q <= x[XW-1];
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (dout.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			sample_q <= din.sample;
		end
		if (out_load) begin
			out_data_q <= echo;
		end
	end

	a_len_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_CLEAR && state_q != ST_IDLE) |-> (len_q != '0 && LW'(wi_q) < len_q))
		else $error("write head outside current length");

	a_div_done: assert property (@(posedge clk) disable iff (!arst_n)
		mod_done |-> (state_q == ST_DIV))
		else $error("remainder result outside divide wait");

	a_read_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_TAPS) |-> (LW'($past(rd_addr)) < len_q))
		else $error("read position outside current length");

endmodule

// ===== verif/testbench.sv =====
// testbench: self-checking bench for echo_delay_fir_feedback_core, with a
// scoreboard class that predicts each echo sample and checks the output stream.
// Depends on edfb_pkg, edfb_in_if, edfb_out_if and the core.
module testbench;
	import edfb_pkg::*;

	class echo_scoreboard #(int DEPTH = 8192);
		logic signed [15:0] store [DEPTH];
		logic signed [15:0] fir_line [8];
		int head;
		int cur_len;
		cfg_t cfg;
		logic signed [15:0] pending_echo [$];
		int items;
		int head_resets;
		int checked;
		int mismatches;

		function new();
			foreach (store[i]) store[i] = '0;
			foreach (fir_line[i]) fir_line[i] = '0;
			head = 0;
			cur_len = 0;
			cfg = '{target_length: RST_TARGET_LENGTH, delay_offset: RST_DELAY_OFFSET,
				feedback_gain: RST_FEEDBACK_GAIN, filter_mix: RST_FILTER_MIX,
				freeze: RST_FREEZE, filter_gain: RST_FILTER_GAIN,
				coefficients: RST_COEFFICIENTS};
			items = 0;
			head_resets = 0;
			checked = 0;
			mismatches = 0;
		endfunction

		function void set_reg(reg_idx_t idx, logic [63:0] v);
			case (idx)
				REG_TARGET_LENGTH: cfg.target_length = v[13:0];
				REG_DELAY_OFFSET:  cfg.delay_offset = v[13:0];
				REG_FEEDBACK_GAIN: cfg.feedback_gain = v[7:0];
				REG_FILTER_MIX:    cfg.filter_mix = v[8:0];
				REG_FREEZE:        cfg.freeze = v[0];
				REG_FILTER_GAIN:   cfg.filter_gain = v[3:0];
				REG_COEFFICIENTS:  cfg.coefficients = v;
				default: ;
			endcase
		endfunction

		static function int wrap16(int v);
			logic signed [15:0] t;
			t = v[15:0];
			return int'(t);
		endfunction

		function void note_item(logic signed [15:0] smp, logic rh);
			int tgt, pos, d, s, f, c, mix, m, wb;
			int k;
			items++;
			if (rh) begin
				head_resets++;
				head = 0;
				cur_len = 0;
			end
			head = (cur_len != 0) ? (head + 1) % cur_len : 0;
			tgt = int'(cfg.target_length);
			if (tgt < 1) tgt = 1;
			if (tgt > DEPTH) tgt = DEPTH;
			if (head == 0 && tgt != cur_len) cur_len = tgt;
			pos = (head + int'($signed(cfg.delay_offset))) % cur_len;
			if (pos < 0) pos += cur_len;
			d = wrap16(int'(store[pos]) * 2);

			for (k = 0; k < 7; k++) fir_line[k] = fir_line[k + 1];
			fir_line[7] = d[15:0];
			s = 0;
			for (k = 0; k < 7; k++) begin
				c = int'($signed(cfg.coefficients[8 * k +: 8]));
				s += (c * int'(fir_line[k])) >>> 7;
			end
			s = wrap16(s);
			c = int'($signed(cfg.coefficients[63:56]));
			s = wrap16(s + ((c * d) >>> 7));
			f = wrap16(s * int'(cfg.filter_gain));

			mix = (cfg.filter_mix > 9'd256) ? 256 : int'(cfg.filter_mix);
			m = wrap16((d * 256 + (f - d) * mix) / 256);

			if (!cfg.freeze) begin
				wb = (int'(smp) + (m * int'($signed(cfg.feedback_gain))) / 128) >>> 1;
				store[head] = wb[15:0];
			end
			pending_echo.push_back(m[15:0]);
		endfunction

		function void check_echo(logic signed [15:0] got);
			logic signed [15:0] want;
			if (pending_echo.size() == 0) begin
				mismatches++;
				$error("echo_sample: expected none pending, got %0d", got);
			end else begin
				want = pending_echo.pop_front();
				checked++;
				if (got !== want) begin
					mismatches++;
					$error("echo_sample: expected %0d, got %0d", want, got);
				end
			end
		endfunction

		function int pending();
			return pending_echo.size();
		endfunction
	endclass

	localparam int ECHO_DEPTH  = 8192;
	localparam int QUIET_LIMIT = 50000;
	localparam int TAIL_CYCLES = 40;

	typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_t;

	logic clk = 1'b0;
	logic arst_n;
	logic psel;
	logic penable;
	logic pwrite;
	logic [ADDR_W-1:0] paddr;
	logic [DATA_W-1:0] pwdata;
	logic [DATA_W-1:0] prdata;
	logic pready;

	idle_mode_t idle_mode = IDLE_NONE;
	int quiet_cycles = 0;
	int settings_used = 0;

	echo_scoreboard #(ECHO_DEPTH) sb;

	edfb_in_if  in_ch();
	edfb_out_if out_ch();

	echo_delay_fir_feedback_core #(.ECHO_DEPTH(ECHO_DEPTH)) u_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.din     (in_ch),
		.dout    (out_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		case (idle_mode)
			IDLE_RECV: out_ch.ready <= ($urandom_range(0, 99) >= 60);
			IDLE_BOTH: out_ch.ready <= ($urandom_range(0, 99) >= 6);
			default:   out_ch.ready <= 1'b1;
		endcase
	end

	always @(posedge clk) begin
		if (arst_n === 1'b1 && in_ch.valid === 1'b1 && in_ch.ready === 1'b1)
			sb.note_item(in_ch.sample, in_ch.reset_head);
		if (arst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1)
			sb.check_echo(out_ch.echo_sample);
	end

	always @(posedge clk) begin
		if ((in_ch.valid === 1'b1 && in_ch.ready === 1'b1)
				|| (out_ch.valid === 1'b1 && out_ch.ready === 1'b1)
				|| (psel && penable && pwrite && pready === 1'b1)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("tb: failure");
				$finish;
			end
		end
	end

	task automatic program_regs(cfg_t c);
		logic [63:0] v;
		reg_idx_t idx;
		for (int i = 0; i <= int'(REG_COEFFICIENTS); i++) begin
			idx = reg_idx_t'(i);
			case (idx)
				REG_TARGET_LENGTH: v = 64'(c.target_length);
				REG_DELAY_OFFSET:  v = 64'(c.delay_offset);
				REG_FEEDBACK_GAIN: v = 64'(c.feedback_gain);
				REG_FILTER_MIX:    v = 64'(c.filter_mix);
				REG_FREEZE:        v = 64'(c.freeze);
				REG_FILTER_GAIN:   v = 64'(c.filter_gain);
				default:           v = c.coefficients;
			endcase
			psel <= 1'b1;
			penable <= 1'b0;
			pwrite <= 1'b1;
			paddr <= ADDR_W'(8 * i);
			pwdata <= v;
			@(posedge clk);
			penable <= 1'b1;
			@(posedge clk);
			while (pready !== 1'b1) @(posedge clk);
			sb.set_reg(idx, v);
		end
		psel <= 1'b0;
		penable <= 1'b0;
		settings_used++;
	endtask

	function automatic bit sender_gap();
		case (idle_mode)
			IDLE_SEND: return $urandom_range(0, 99) < 60;
			IDLE_BOTH: return $urandom_range(0, 99) < 6;
			default:   return 1'b0;
		endcase
	endfunction

	task automatic send_item(logic signed [15:0] smp, logic rh);
		while (sender_gap()) begin
			in_ch.valid <= 1'b0;
			@(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.sample <= smp;
		in_ch.reset_head <= rh;
		@(posedge clk);
		while (in_ch.ready !== 1'b1) @(posedge clk);
	endtask

	task automatic finish_phase();
		in_ch.valid <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0) @(posedge clk);
	endtask

	task automatic run_directed();
		logic signed [15:0] extremes [12];
		cfg_t c;
		extremes = '{16'sh7FFF, 16'sh8000, 16'sh0000, 16'shFFFF, 16'sh0001, 16'sh4000,
			16'shBFFF, 16'sh5555, 16'shAAAA, 16'sh7FFF, 16'sh8000, 16'sh3039};

		// short loop, read offset past the length, feedback -128, mix above full
		c = '{target_length: 14'd5, delay_offset: 14'h3FF9, feedback_gain: 8'h80,
			filter_mix: 9'd300, freeze: 1'b0, filter_gain: 4'd15,
			coefficients: 64'h807FC04001FF7F80};
		program_regs(c);
		foreach (extremes[i]) send_item(extremes[i], i == 0 || i == 7);
		finish_phase();

		// zero target, frozen store, raw path only
		c = '{target_length: 14'd0, delay_offset: 14'd8191, feedback_gain: 8'd127,
			filter_mix: 9'd0, freeze: 1'b1, filter_gain: 4'd0,
			coefficients: 64'h8080808080808080};
		program_regs(c);
		for (int i = 0; i < 6; i++) send_item(extremes[i], i == 0);
		finish_phase();

		// target above the depth, offset of -8191
		c = '{target_length: 14'h3FFF, delay_offset: 14'h2001, feedback_gain: 8'h81,
			filter_mix: 9'd256, freeze: 1'b0, filter_gain: 4'd1,
			coefficients: 64'h7F7F7F7F7F7F7F7F};
		program_regs(c);
		for (int i = 6; i < 12; i++) send_item(extremes[i], i == 6);
		finish_phase();
	endtask

	task automatic run_random_phase(int n_items, int len_kind);
		cfg_t c;
		int span;
		int off_i;
		case (len_kind)
			1:       c.target_length = 14'd0;
			2:       c.target_length = 14'($urandom_range(ECHO_DEPTH, 16383));
			3:       c.target_length = 14'($urandom_range(0, 16383));
			default: c.target_length = 14'($urandom_range(1, 48));
		endcase
		span = (c.target_length == 0) ? 1 : int'(c.target_length);
		if (span > 4096) span = 4096;
		if ($urandom_range(0, 3) == 0) begin
			c.delay_offset = 14'($urandom);
		end else begin
			off_i = int'($urandom_range(0, 4 * span)) - 2 * span;
			if (off_i > 8191) off_i = 8191;
			if (off_i < -8191) off_i = -8191;
			c.delay_offset = off_i[13:0];
		end
		c.feedback_gain = 8'($urandom);
		c.filter_mix = ($urandom_range(0, 2) == 0) ? 9'($urandom) : 9'($urandom_range(0, 256));
		c.freeze = ($urandom_range(0, 3) == 0);
		c.filter_gain = 4'($urandom);
		c.coefficients = {$urandom, $urandom};
		program_regs(c);
		for (int i = 0; i < n_items; i++)
			send_item(16'($urandom), i == 0 || $urandom_range(0, 15) == 0);
		finish_phase();
	endtask

	initial begin
		int kind;
		sb = new();
		arst_n <= 1'b0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		in_ch.valid <= 1'b0;
		in_ch.sample <= '0;
		in_ch.reset_head <= 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		run_directed();
		for (int p = 0; p < 8; p++) begin
			idle_mode <= idle_mode_t'(p % 4);
			kind = (p == 1) ? 1 : (p == 4) ? 2 : (p == 6) ? 3 : 0;
			run_random_phase(92, kind);
		end

		repeat (TAIL_CYCLES) @(posedge clk);
		$display("run: %0d samples in (%0d with head reset), %0d echo samples checked,",
			sb.items, sb.head_resets, sb.checked);
		$display("run: %0d register settings, %0d mismatches", settings_used, sb.mismatches);
		if (sb.mismatches == 0 && sb.pending() == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end
endmodule
